// ===== src/itc_pkg.sv =====
// Shared types, constants and the checksum fold for the IPv4/TCP checker.
package itc_pkg;

    localparam int CountW  = 17;
    localparam int SizeW   = CountW + 1;
    localparam int IpSumW  = 25;
    localparam int TcpSumW = 34;
    localparam int SpanW   = 18;

    localparam logic [CountW-1:0] CountMax    = '1;
    localparam logic [CountW-1:0] IdxVerIhl   = 17'd0;
    localparam logic [CountW-1:0] IdxLenHigh  = 17'd2;
    localparam logic [CountW-1:0] IdxLenLow   = 17'd3;
    localparam logic [CountW-1:0] IdxFragHigh = 17'd6;
    localparam logic [CountW-1:0] IdxFragLow  = 17'd7;
    localparam logic [CountW-1:0] IdxProtocol = 17'd9;
    localparam logic [CountW-1:0] IdxCsumLo   = 17'd10;
    localparam logic [CountW-1:0] IdxAddrLo   = 17'd12;
    localparam logic [CountW-1:0] IdxAddrEnd  = 17'd20;
    localparam logic [CountW-1:0] SegOffData  = 17'd12;
    localparam logic [CountW-1:0] SegOffCsumH = 17'd16;
    localparam logic [CountW-1:0] SegOffCsumL = 17'd17;

    localparam logic [3:0]       VersionIpv4  = 4'd4;
    localparam logic [3:0]       MinWords     = 4'd5;
    localparam logic [7:0]       ProtocolTcp  = 8'd6;
    localparam logic [15:0]      MinHdrBytes  = 16'd20;
    localparam logic [SizeW-1:0] MinPktBytes  = 18'd20;
    localparam logic [SpanW-1:0] MaxSpan      = 18'd65535;
    localparam logic [15:0]      FoldAllOnes  = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } itc_in_t;

    typedef struct packed {
        logic [15:0] ip_header_checksum;
        logic [15:0] tcp_csum;
        logic        packet_valid;
        logic        segment_valid;
    } itc_out_t;

    typedef struct packed {
        logic [3:0]  version;
        logic [3:0]  ihl;
        logic [15:0] pkt_len;
        logic [15:0] frag_word;
        logic [7:0]  protocol;
    } itc_hdr_t;

    typedef struct packed {
        logic [15:0]      ip_sum_high;
        logic [15:0]      ip_sum_low;
        logic [23:0]      tcp_sum_high;
        logic [23:0]      tcp_sum_low;
        itc_hdr_t         hdr;
        logic [3:0]       tcp_offset_nibble;
        logic [SizeW-1:0] size;
    } itc_snap_t;

    typedef struct packed {
        logic [IpSumW-1:0]  ip_sum;
        logic [TcpSumW-1:0] tcp_sum;
        logic               packet_valid;
        logic               segment_valid;
    } itc_sums_t;

    function automatic logic [15:0] itc_fold16(input logic [TcpSumW-1:0] s);
        logic [18:0] s1;
        logic [16:0] s2;
        logic [16:0] s3;
        s1 = {3'b0, s[15:0]} + {1'b0, s[33:16]};
        s2 = {1'b0, s1[15:0]} + {14'b0, s1[18:16]};
        s3 = {1'b0, s2[15:0]} + {16'b0, s2[16]};
        if (s3 == {1'b0, FoldAllOnes}) begin
            return FoldAllOnes;
        end
        return ~s3[15:0];
    endfunction

endpackage

// ===== src/ipv4_tcp_check_and_checksum_top.sv =====
// Top level of the IPv4 header and TCP checksum checker.
//
//   Channel   Ports                      Beat
//   input     s_valid, s_ready, s_data   one packet byte with its last-byte mark
//   result    m_valid, m_ready, m_data   both checksums and two validity flags
//
// One byte is taken per cycle unless a last byte waits on a full snapshot; the running sums take in each byte.
// A result leaves after its last byte has passed the input register,
// snapshot register, sum register and result register in turn.
// Reset is synchronous on aresetn and empties every stage and clears the running sums.
// A stalled result holds the stages behind it; input stops only when a last byte waits and all are full.
module ipv4_tcp_check_and_checksum_top import itc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  itc_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output itc_out_t m_data
);

    logic      in_valid_reg;
    itc_in_t   in_beat_reg;
    logic      accum_ready, accum_consume;
    logic      snap_valid, sum_ready;
    itc_snap_t snap;
    logic      sums_valid, fold_ready;
    itc_sums_t sums;

    assign accum_consume = in_valid_reg && accum_ready;
    assign s_ready       = !in_valid_reg || accum_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_beat_reg <= s_data;
        end
    end

    itc_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_beat   (in_beat_reg),
        .in_ready  (accum_ready),
        .out_ready (sum_ready),
        .out_valid (snap_valid),
        .out_snap  (snap)
    );

    itc_sum u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (snap_valid),
        .in_snap   (snap),
        .in_ready  (sum_ready),
        .out_ready (fold_ready),
        .out_valid (sums_valid),
        .out_sums  (sums)
    );

    itc_fold u_fold (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (sums_valid),
        .in_sums  (sums),
        .in_ready (fold_ready),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_data   (m_data)
    );

    a_snap_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(snap_valid) |-> $past(accum_consume && in_beat_reg.last_byte))
        else $error("Snapshot appeared without a consumed last beat.");

    a_result_from_sums: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(sums_valid))
        else $error("Result appeared without a pending sum stage.");

    a_beat_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !accum_consume |=> in_valid_reg && $stable(in_beat_reg))
        else $error("Registered input beat was lost before consumption.");

endmodule

// ===== src/itc_accum.sv =====
// Per-byte header capture, lane accumulators and the end-of-packet snapshot register.
module itc_accum import itc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  itc_in_t   in_beat,
    output logic      in_ready,
    input  logic      out_ready,
    output logic      out_valid,
    output itc_snap_t out_snap
);

    logic [CountW-1:0] count_reg, count_next;
    logic [15:0]       ip_hi_reg, ip_hi_next, ip_lo_reg, ip_lo_next;
    logic [23:0]       tcp_hi_reg, tcp_hi_next, tcp_lo_reg, tcp_lo_next;
    itc_hdr_t          hdr_reg, hdr_next;
    logic [3:0]        nib_reg, nib_next;
    logic              snap_valid_reg;
    itc_snap_t         snap_reg;

    logic [7:0]        d;
    logic [5:0]        hlen;
    logic [CountW-1:0] hlen_ext, seg_off;
    logic              ip_take, pseudo_take, seg_take, seg_add, snap_free, consume;
    logic [23:0]       d24, p_hi, p_lo, s_hi, s_lo;

    assign d         = in_beat.data_byte;
    assign d24       = {16'b0, d};
    assign snap_free = !snap_valid_reg || out_ready;
    assign in_ready  = !in_beat.last_byte || snap_free;
    assign consume   = in_valid && in_ready;

    always_comb begin
        hdr_next = hdr_reg;
        case (count_reg)
            IdxVerIhl: begin
                hdr_next.version = d[7:4];
                hdr_next.ihl     = d[3:0];
            end
            IdxLenHigh:  hdr_next.pkt_len[15:8]   = d;
            IdxLenLow:   hdr_next.pkt_len[7:0]    = d;
            IdxFragHigh: hdr_next.frag_word[15:8] = d;
            IdxFragLow:  hdr_next.frag_word[7:0]  = d;
            IdxProtocol: hdr_next.protocol        = d;
            default: ;
        endcase
    end

    always_comb begin
        hlen        = {hdr_next.ihl, 2'b00};
        hlen_ext    = {{(CountW-6){1'b0}}, hlen};
        ip_take     = (count_reg < IdxCsumLo) ||
                      (count_reg >= IdxAddrLo && count_reg < hlen_ext);
        pseudo_take = (count_reg >= IdxAddrLo) && (count_reg < IdxAddrEnd);
        seg_take    = (count_reg >= hlen_ext) &&
                      (count_reg < {1'b0, hdr_next.pkt_len});
        seg_off     = count_reg - hlen_ext;
        seg_add     = seg_take && seg_off != SegOffCsumH && seg_off != SegOffCsumL;
        nib_next    = (seg_take && seg_off == SegOffData) ? d[7:4] : nib_reg;

        p_hi = (pseudo_take && !count_reg[0]) ? d24 : 24'b0;
        p_lo = (pseudo_take &&  count_reg[0]) ? d24 : 24'b0;
        s_hi = (seg_add && !seg_off[0]) ? d24 : 24'b0;
        s_lo = (seg_add &&  seg_off[0]) ? d24 : 24'b0;

        tcp_hi_next = tcp_hi_reg + p_hi + s_hi;
        tcp_lo_next = tcp_lo_reg + p_lo + s_lo;
        ip_hi_next  = ip_hi_reg + ((ip_take && !count_reg[0]) ? {8'b0, d} : 16'b0);
        ip_lo_next  = ip_lo_reg + ((ip_take &&  count_reg[0]) ? {8'b0, d} : 16'b0);
        count_next  = (count_reg == CountMax) ? count_reg : count_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            ip_hi_reg  <= '0;
            ip_lo_reg  <= '0;
            tcp_hi_reg <= '0;
            tcp_lo_reg <= '0;
            hdr_reg    <= '0;
            nib_reg    <= '0;
        end else if (consume) begin
            if (in_beat.last_byte) begin
                count_reg  <= '0;
                ip_hi_reg  <= '0;
                ip_lo_reg  <= '0;
                tcp_hi_reg <= '0;
                tcp_lo_reg <= '0;
                hdr_reg    <= '0;
                nib_reg    <= '0;
            end else begin
                count_reg  <= count_next;
                ip_hi_reg  <= ip_hi_next;
                ip_lo_reg  <= ip_lo_next;
                tcp_hi_reg <= tcp_hi_next;
                tcp_lo_reg <= tcp_lo_next;
                hdr_reg    <= hdr_next;
                nib_reg    <= nib_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (consume && in_beat.last_byte) begin
            snap_valid_reg <= 1'b1;
        end else if (out_ready) begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && in_beat.last_byte) begin
            snap_reg.ip_sum_high       <= ip_hi_next;
            snap_reg.ip_sum_low        <= ip_lo_next;
            snap_reg.tcp_sum_high      <= tcp_hi_next;
            snap_reg.tcp_sum_low       <= tcp_lo_next;
            snap_reg.hdr               <= hdr_next;
            snap_reg.tcp_offset_nibble <= nib_next;
            snap_reg.size              <= {1'b0, count_reg} + 1'b1;
        end
    end

    assign out_valid = snap_valid_reg;
    assign out_snap  = snap_reg;

endmodule

// ===== src/itc_sum.sv =====
// Validity checks and the combined wide sums, registered ahead of the fold.
module itc_sum import itc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  itc_snap_t in_snap,
    output logic      in_ready,
    input  logic      out_ready,
    output logic      out_valid,
    output itc_sums_t out_sums
);

    logic       valid_reg;
    itc_sums_t  sums_reg, sums_next;
    logic [5:0] hlen;
    logic [15:0] hlen16, tcp_len;
    logic [12:0] foff;
    logic        mf;
    logic [SpanW-1:0] span;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        hlen    = {in_snap.hdr.ihl, 2'b00};
        hlen16  = {10'b0, hlen};
        tcp_len = in_snap.hdr.pkt_len - hlen16;
        foff    = in_snap.hdr.frag_word[12:0];
        mf      = in_snap.hdr.frag_word[13];
        span    = {2'b0, MinHdrBytes} + {2'b0, foff, 3'b000} + {2'b0, tcp_len};

        sums_next.packet_valid = (in_snap.size >= MinPktBytes) &&
                                 (in_snap.hdr.version == VersionIpv4) &&
                                 (in_snap.hdr.ihl >= MinWords) &&
                                 ({2'b0, in_snap.hdr.pkt_len} <= in_snap.size) &&
                                 (in_snap.hdr.pkt_len >= hlen16) &&
                                 (span <= MaxSpan);
        sums_next.segment_valid = (in_snap.hdr.protocol == ProtocolTcp) && !mf &&
                                  (foff == 13'd0) && (tcp_len >= MinHdrBytes) &&
                                  (in_snap.tcp_offset_nibble >= MinWords) &&
                                  (tcp_len >= {10'b0, in_snap.tcp_offset_nibble, 2'b00});
        sums_next.ip_sum  = {1'b0, in_snap.ip_sum_high, 8'b0} + {9'b0, in_snap.ip_sum_low};
        sums_next.tcp_sum = {2'b0, in_snap.tcp_sum_high, 8'b0} +
                            {10'b0, in_snap.tcp_sum_low} +
                            {26'b0, in_snap.hdr.protocol} + {18'b0, tcp_len};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sums_reg <= sums_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_sums  = sums_reg;

endmodule

// ===== src/itc_fold.sv =====
// Carry fold and complement of both checksums into the result register.
module itc_fold import itc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  itc_sums_t in_sums,
    output logic      in_ready,
    input  logic      m_ready,
    output logic      m_valid,
    output itc_out_t  m_data
);

    logic     valid_reg;
    itc_out_t data_reg, data_next;

    assign in_ready = !valid_reg || m_ready;

    always_comb begin
        data_next.ip_header_checksum = itc_fold16({{(TcpSumW-IpSumW){1'b0}}, in_sums.ip_sum});
        data_next.tcp_csum           = itc_fold16(in_sums.tcp_sum);
        data_next.packet_valid       = in_sums.packet_valid;
        data_next.segment_valid      = in_sums.segment_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule
